FILE: rtl/i2a_pkg.sv
// Shared types, constants and elaboration-time helpers for int_to_decimal_ascii.
// Used by i2a_dabble and int_to_decimal_ascii; depends on nothing else.
package i2a_pkg;

  localparam int MAG_W          = 32;             // magnitude width, covers -(2**31)
  localparam int HW_DIGITS      = 10;             // digits a 32-bit magnitude can need
  localparam int BCD_W          = 4 * HW_DIGITS;
  localparam int CNT_W          = 4;              // holds 0..HW_DIGITS
  localparam int MAX_DIGITS_DEF = 10;
  localparam int DABBLE_STAGES  = 4;
  localparam int DABBLE_STEPS   = MAG_W / DABBLE_STAGES;
  localparam int CHR_W          = 6;

  localparam logic [CHR_W-1:0] CHR_ZERO  = 6'd48;
  localparam logic [CHR_W-1:0] CHR_MINUS = 6'd45;
  localparam logic [CHR_W-1:0] CHR_NINE  = 6'd57;

  // One shift-add-3 pipeline slot: binary bits still to go and BCD built so far.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] bin;
  } dd_t;

  // Largest magnitude that the digit limit can show (all nines), clamped to 1..HW_DIGITS.
  function automatic logic [63:0] sat_cap(input int lim);
    int          m;
    logic [63:0] c;
    m = lim;
    if (m < 1) m = 1;
    if (m > HW_DIGITS) m = HW_DIGITS;
    c = 64'd1;
    for (int i = 0; i < m; i++) c = c * 64'd10;
    return c - 64'd1;
  endfunction

endpackage

FILE: rtl/i2a_dabble.sv
// One register stage of the pipelined binary-to-BCD converter (shift-add-3).
// Uses i2a_pkg for the slot type and step count.
module i2a_dabble (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  i2a_pkg::dd_t d,
  output i2a_pkg::dd_t q
);

  i2a_pkg::dd_t nxt;

  always_comb begin
    nxt = d;
    for (int s = 0; s < i2a_pkg::DABBLE_STEPS; s++) begin
      for (int k = 0; k < i2a_pkg::HW_DIGITS; k++) begin
        if (nxt.bcd[4*k +: 4] >= 4'd5) begin
          nxt.bcd[4*k +: 4] = nxt.bcd[4*k +: 4] + 4'd3;
        end
      end
      {nxt.bcd, nxt.bin} = {nxt.bcd[i2a_pkg::BCD_W-2:0], nxt.bin, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.neg <= nxt.neg;
      q.bcd <= nxt.bcd;
      q.bin <= nxt.bin;
    end
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= nxt.valid;
    end
  end

endmodule

FILE: rtl/int_to_decimal_ascii.sv
// Top level of int_to_decimal_ascii: signed 32-bit integer to decimal ASCII characters.
// Depends on i2a_pkg and i2a_dabble.

// Each input beat carries one signed 32-bit value; the block returns its decimal
// text as a run of 1 to 11 output beats, most significant character first, with a
// leading '-' for negative values and tlast on the final digit. Zero gives "0" and
// the most negative value gives "-2147483648". If MAX_DIGITS is smaller than the
// digits a magnitude needs, the magnitude saturates to all nines. An input value
// runs through seven register stages (sign/magnitude, saturate, four shift-add-3
// BCD stages, digit count and alignment) and then a character serializer. The
// serializer sends one character per cycle while the sink is ready, so the length
// of a value's text sets how long it occupies the serializer and the sustained
// rate; the next value is loaded in the same cycle as the previous run's last
// character is sent, so runs follow with no gap. Upstream stages keep taking
// values until the pipeline backs up against the serializer.
module int_to_decimal_ascii #(
  parameter int MAX_DIGITS = i2a_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] ascii_char, [7:6] zero
  output logic        m_axis_tlast
);

  localparam logic [63:0] CAP = i2a_pkg::sat_cap(MAX_DIGITS);
  localparam int MW = i2a_pkg::MAG_W;
  localparam int BW = i2a_pkg::BCD_W;
  localparam int CW = i2a_pkg::CNT_W;

  // Whole pipeline advances together; a stall holds every stage.
  logic adv;

  // Stage A: sign and magnitude. Two's-complement negate in 32 bits gives
  // 0x80000000 for the most negative value, which is its correct magnitude.
  logic          a_valid;
  logic          a_neg;
  logic [MW-1:0] a_mag;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_neg <= s_axis_tdata[MW-1];
      a_mag <= s_axis_tdata[MW-1] ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
    end
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_axis_tvalid;
    end
  end

  // Stage B: clamp to the digit limit and seed the BCD converter.
  i2a_pkg::dd_t b;

  always_ff @(posedge clk) begin
    if (adv) begin
      b.neg <= a_neg;
      b.bcd <= '0;
      b.bin <= ({32'd0, a_mag} > CAP) ? CAP[MW-1:0] : a_mag;
    end
    if (rst) begin
      b.valid <= 1'b0;
    end else if (adv) begin
      b.valid <= a_valid;
    end
  end

  // Stages C..F: shift-add-3, a quarter of the magnitude bits in each.
  i2a_pkg::dd_t dd [i2a_pkg::DABBLE_STAGES+1];

  assign dd[0] = b;

  for (genvar g = 0; g < i2a_pkg::DABBLE_STAGES; g++) begin : g_dabble
    i2a_dabble u_stage (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (dd[g]),
      .q   (dd[g+1])
    );
  end

  // Stage G: count significant digits and left-align the most significant one.
  logic          al_valid;
  logic          al_neg;
  logic [CW-1:0] al_n;
  logic [BW-1:0] al_bcd;
  logic [CW-1:0] cnt;
  logic [CW-1:0] sh;
  logic [BW-1:0] conv;

  assign conv = dd[i2a_pkg::DABBLE_STAGES].bcd;

  always_comb begin
    cnt = CW'(1);
    for (int k = 1; k < i2a_pkg::HW_DIGITS; k++) begin
      if (conv[4*k +: 4] != 4'd0) begin
        cnt = CW'(k + 1);
      end
    end
    sh = CW'(i2a_pkg::HW_DIGITS) - cnt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      al_neg <= dd[i2a_pkg::DABBLE_STAGES].neg;
      al_n   <= cnt;
      al_bcd <= conv << {sh, 2'b00};
    end
    if (rst) begin
      al_valid <= 1'b0;
    end else if (adv) begin
      al_valid <= dd[i2a_pkg::DABBLE_STAGES].valid;
    end
  end

  // Serializer: sign first, then digits from the top nibble down.
  logic          ser_valid;
  logic          ser_sign;
  logic [CW-1:0] ser_left;
  logic [BW-1:0] ser_bcd;
  logic          emit;
  logic          ser_done;
  logic          ser_load;

  assign emit     = ser_valid && (!m_axis_tvalid || m_axis_tready);
  assign ser_done = emit && !ser_sign && (ser_left == CW'(1));
  assign ser_load = al_valid && (!ser_valid || ser_done);
  assign adv      = !al_valid || ser_load;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_sign <= al_neg;
      ser_left <= al_n;
      ser_bcd  <= al_bcd;
    end else if (emit) begin
      if (ser_sign) begin
        ser_sign <= 1'b0;
      end else begin
        ser_left <= ser_left - CW'(1);
        ser_bcd  <= {ser_bcd[BW-5:0], 4'd0};
      end
    end
    if (rst) begin
      ser_valid <= 1'b0;
    end else if (ser_load) begin
      ser_valid <= 1'b1;
    end else if (ser_done) begin
      ser_valid <= 1'b0;
    end
  end

  // Output register: hold the character until the sink takes it.
  logic [i2a_pkg::CHR_W-1:0] o_chr;

  always_ff @(posedge clk) begin
    if (emit) begin
      if (ser_sign) begin
        o_chr        <= i2a_pkg::CHR_MINUS;
        m_axis_tlast <= 1'b0;
      end else begin
        o_chr        <= i2a_pkg::CHR_ZERO + {2'b00, ser_bcd[BW-1 -: 4]};
        m_axis_tlast <= (ser_left == CW'(1));
      end
    end
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {2'b00, o_chr};

`ifndef SYNTHESIS
  a_chr_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (o_chr == i2a_pkg::CHR_MINUS) ||
                      ((o_chr >= i2a_pkg::CHR_ZERO) && (o_chr <= i2a_pkg::CHR_NINE)))
    else $error("output character outside '-' and '0'..'9'");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && o_chr == i2a_pkg::CHR_MINUS) |-> !m_axis_tlast)
    else $error("minus sign flagged as last character");

  a_ser_has_digits: assert property (@(posedge clk) disable iff (rst)
    ser_valid |-> (ser_left != '0) && (ser_left <= CW'(i2a_pkg::HW_DIGITS)))
    else $error("serializer busy with no digits left");

  a_load_after_last: assert property (@(posedge clk) disable iff (rst)
    (ser_valid && $past(ser_valid) && !$past(rst) && $past(ser_done) && !$past(ser_load))
      |-> 1'b0)
    else $error("serializer stayed busy after its last digit");
`endif

endmodule
